>>> design/pasm_pkg.sv
package pasm_pkg;

  localparam int MAX_TERMS_DEF  = 32;
  localparam int COEF_WIDTH_DEF = 16;

  localparam int EXP_IN_W  = 5;
  localparam int COEF_IN_W = 16;
  localparam int EXP_OUT_W = 6;
  localparam int ACC_W     = 37;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_TERM    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDSUB,
    S_MUL,
    S_DRAIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage

>>> design/pasm_cell.sv
module pasm_cell
  import pasm_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic signed [COEF_WIDTH-1:0] a,
  input  logic signed [COEF_WIDTH-1:0] b,
  input  logic        [ACC_W-1:0]      acc_in,
  output logic        [ACC_W-1:0]      acc_out
);

  logic signed [2*COEF_WIDTH-1:0] prod;
  logic        [ACC_W-1:0]        prod_ext;
  logic        [ACC_W-1:0]        acc_r;

  assign prod     = a * b;
  assign prod_ext = ACC_W'(64'(prod));
  assign acc_out  = acc_r;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.shift) begin
      acc_r <= acc_in + prod_ext;
    end
  end

endmodule

>>> design/polynomial_add_sub_mul_unit.sv
// Polynomial add/subtract/multiply unit. A load (first or second operand term)
// gives no result. A compute keeps busy high while it runs: add and subtract
// walk the exponents from MAX_TERMS-1 down; multiply runs MAX_TERMS Horner
// steps through the row of product cells, then shifts the 2*MAX_TERMS-1 cell
// accumulators out past the top cell. An invalid operation answers with one
// ST_INVALID beat and does not raise busy. Results leave one per cycle at most,
// each on the out_ ports for a single cycle marked by out_valid; the receiver
// cannot stall and must take every beat. The final beat of a compute carries
// out_last_term.
module polynomial_add_sub_mul_unit
  import pasm_pkg::*;
#(
  parameter int MAX_TERMS  = MAX_TERMS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [EXP_IN_W-1:0]         in_term_exponent,
  input  logic signed [COEF_IN_W-1:0] in_term_coefficient,
  input  logic [1:0]                  in_operation,
  output logic                        out_valid,
  output logic [EXP_OUT_W-1:0]        out_exponent,
  output logic signed [ACC_W-1:0]     out_coefficient,
  output logic [1:0]                  out_status,
  output logic                        out_last_term
);

  localparam int ACC_DEPTH = 2 * MAX_TERMS - 1;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(ACC_DEPTH);
  localparam int CMAX      = (1 << (COEF_WIDTH - 1)) - 1;
  localparam int CMIN      = -CMAX - 1;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic sub_r, sub_nxt;
  logic pend_vld_r, pend_vld_nxt;
  logic [EXP_OUT_W-1:0] pend_exp_r, pend_exp_nxt;
  logic [ACC_W-1:0] pend_coef_r, pend_coef_nxt;
  logic ov_r, ov_nxt;
  logic [EXP_OUT_W-1:0] oe_r, oe_nxt;
  logic [ACC_W-1:0] oc_r, oc_nxt;
  status_t os_r, os_nxt;
  logic ol_r, ol_nxt;

  logic signed [COEF_WIDTH-1:0] a_coef_r [MAX_TERMS];
  logic signed [COEF_WIDTH-1:0] b_coef_r [MAX_TERMS];
  logic [MAX_TERMS-1:0] a_pres_r, b_pres_r;

  cell_ctl_t ctl;
  logic clr_pres;
  logic hit;
  logic [EXP_OUT_W-1:0] hit_exp;
  logic [ACC_W-1:0] hit_coef;

  logic signed [31:0] c32;
  logic signed [COEF_WIDTH-1:0] c_sat;
  logic exp_ok;
  logic [IDX_W-1:0] idx;
  logic [ACC_W-1:0] va, vb, as_val;
  logic signed [COEF_WIDTH-1:0] a_cur;
  logic [ACC_W-1:0] acc [ACC_DEPTH];
  logic load_a, load_b;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    c32 = 32'(in_term_coefficient);
    if (c32 > CMAX) begin
      c32 = CMAX;
    end else if (c32 < CMIN) begin
      c32 = CMIN;
    end
    c_sat = COEF_WIDTH'(c32);
  end

  assign exp_ok = (32'(in_term_exponent) < MAX_TERMS);
  assign load_a = start && !busy && (in_req_type == REQ_LOAD_A) && exp_ok;
  assign load_b = start && !busy && (in_req_type == REQ_LOAD_B) && exp_ok;

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_coef_r[in_term_exponent[IDX_W-1:0]] <= c_sat;
    end
    if (load_b) begin
      b_coef_r[in_term_exponent[IDX_W-1:0]] <= c_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_pres_r <= '0;
      b_pres_r <= '0;
    end else if (clr_pres) begin
      a_pres_r <= '0;
      b_pres_r <= '0;
    end else begin
      if (load_a) begin
        a_pres_r[in_term_exponent[IDX_W-1:0]] <= 1'b1;
      end
      if (load_b) begin
        b_pres_r[in_term_exponent[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  assign idx = cnt_r[IDX_W-1:0];
  assign va  = a_pres_r[idx] ? ACC_W'(32'(a_coef_r[idx])) : '0;
  assign vb  = b_pres_r[idx] ? ACC_W'(32'(b_coef_r[idx])) : '0;
  assign as_val = sub_r ? (va - vb) : (va + vb);
  assign a_cur  = (state_r == S_MUL && a_pres_r[idx]) ? a_coef_r[idx] : '0;

  for (genvar k = 0; k < ACC_DEPTH; k++) begin : g_cell
    logic signed [COEF_WIDTH-1:0] b_k;
    logic [ACC_W-1:0] prev;
    if (k < MAX_TERMS) begin : g_b
      assign b_k = b_pres_r[k] ? b_coef_r[k] : '0;
    end else begin : g_nb
      assign b_k = '0;
    end
    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_next
      assign prev = acc[k-1];
    end
    pasm_cell #(.COEF_WIDTH(COEF_WIDTH)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .a      (a_cur),
      .b      (b_k),
      .acc_in (prev),
      .acc_out(acc[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      sub_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      sub_r      <= sub_nxt;
      pend_vld_r <= pend_vld_nxt;
      ov_r       <= ov_nxt;
    end
    pend_exp_r  <= pend_exp_nxt;
    pend_coef_r <= pend_coef_nxt;
    oe_r        <= oe_nxt;
    oc_r        <= oc_nxt;
    os_r        <= os_nxt;
    ol_r        <= ol_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sub_nxt       = sub_r;
    pend_vld_nxt  = pend_vld_r;
    pend_exp_nxt  = pend_exp_r;
    pend_coef_nxt = pend_coef_r;
    ov_nxt        = 1'b0;
    oe_nxt        = '0;
    oc_nxt        = '0;
    os_nxt        = ST_TERM;
    ol_nxt        = 1'b0;
    ctl           = '0;
    clr_pres      = 1'b0;
    hit           = 1'b0;
    hit_exp       = '0;
    hit_coef      = '0;
    case (state_r)
      S_IDLE: begin
        if (start && in_req_type == REQ_COMPUTE) begin
          case (in_operation)
            OP_ADD, OP_SUB: begin
              state_nxt = S_ADDSUB;
              cnt_nxt   = CNT_W'(MAX_TERMS - 1);
              sub_nxt   = (in_operation == OP_SUB);
            end
            OP_MUL: begin
              state_nxt = S_MUL;
              cnt_nxt   = CNT_W'(MAX_TERMS - 1);
              ctl.clr   = 1'b1;
            end
            default: begin
              ov_nxt   = 1'b1;
              os_nxt   = ST_INVALID;
              ol_nxt   = 1'b1;
              clr_pres = 1'b1;
            end
          endcase
        end
      end
      S_ADDSUB: begin
        hit      = a_pres_r[idx] | b_pres_r[idx];
        hit_exp  = EXP_OUT_W'(cnt_r);
        hit_coef = as_val;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MUL: begin
        ctl.shift = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = CNT_W'(ACC_DEPTH - 1);
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DRAIN: begin
        ctl.shift = 1'b1;
        hit       = (acc[ACC_DEPTH-1] != '0);
        hit_exp   = EXP_OUT_W'(cnt_r);
        hit_coef  = acc[ACC_DEPTH-1];
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        ov_nxt = 1'b1;
        ol_nxt = 1'b1;
        if (pend_vld_r) begin
          oe_nxt = pend_exp_r;
          oc_nxt = pend_coef_r;
        end else begin
          os_nxt = ST_EMPTY;
        end
        pend_vld_nxt = 1'b0;
        clr_pres     = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (hit) begin
      if (pend_vld_r) begin
        ov_nxt = 1'b1;
        oe_nxt = pend_exp_r;
        oc_nxt = pend_coef_r;
      end
      pend_vld_nxt  = 1'b1;
      pend_exp_nxt  = hit_exp;
      pend_coef_nxt = hit_coef;
    end
  end

  assign out_valid       = ov_r;
  assign out_exponent    = oe_r;
  assign out_coefficient = oc_r;
  assign out_status      = os_r;
  assign out_last_term   = ol_r;

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_COMPUTE &&
    (in_operation == OP_ADD || in_operation == OP_SUB || in_operation == OP_MUL)
    |=> busy)
    else $error("compute did not raise busy");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TERM |-> out_last_term)
    else $error("empty or invalid beat without last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TERM |-> out_exponent == '0 && out_coefficient == '0)
    else $error("empty or invalid beat carries a term");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !pend_vld_r)
    else $error("pending term left behind");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_term |-> !busy)
    else $error("last beat while still running");

endmodule

>>> verif/tb.sv
module tb;
  import pasm_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_req_type;
  logic [EXP_IN_W-1:0] in_term_exponent;
  logic signed [COEF_IN_W-1:0] in_term_coefficient;
  logic [1:0] in_operation;
  logic out_valid;
  logic [EXP_OUT_W-1:0] out_exponent;
  logic signed [ACC_W-1:0] out_coefficient;
  logic [1:0] out_status;
  logic out_last_term;

  typedef struct packed {
    logic [EXP_OUT_W-1:0] exponent;
    logic [ACC_W-1:0] coefficient;
    logic [1:0] status;
    logic last;
  } term_t;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] OP_BAD = 2'd3;

  term_t expected_terms[$];
  logic signed [15:0] poly_a_coef[32];
  logic signed [15:0] poly_b_coef[32];
  logic [31:0] poly_a_present;
  logic [31:0] poly_b_present;
  int errors;
  int cycles;
  int items_sent;
  int terms_checked;
  int computes_sent;
  int send_gap_pct;

  polynomial_add_sub_mul_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_term_exponent(in_term_exponent),
    .in_term_coefficient(in_term_coefficient), .in_operation(in_operation),
    .out_valid(out_valid), .out_exponent(out_exponent),
    .out_coefficient(out_coefficient), .out_status(out_status),
    .out_last_term(out_last_term)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic void predict_item(logic [1:0] req, logic [4:0] ex,
                                       logic signed [15:0] coef, logic [1:0] op);
    logic signed [ACC_W-1:0] acc[63];
    logic signed [ACC_W-1:0] v;
    term_t t;
    int n;
    n = 0;
    if (req == REQ_LOAD_A) begin
      poly_a_coef[ex] = coef;
      poly_a_present[ex] = 1'b1;
      return;
    end
    if (req == REQ_LOAD_B) begin
      poly_b_coef[ex] = coef;
      poly_b_present[ex] = 1'b1;
      return;
    end
    if (req != REQ_COMPUTE) return;
    if (op == OP_ADD || op == OP_SUB) begin
      for (int e = 31; e >= 0; e--) begin
        if (!poly_a_present[e] && !poly_b_present[e]) continue;
        v = '0;
        if (poly_a_present[e]) v = poly_a_coef[e];
        if (poly_b_present[e])
          v = (op == OP_SUB) ? v - poly_b_coef[e] : v + poly_b_coef[e];
        t = '{exponent: EXP_OUT_W'(e), coefficient: v, status: ST_TERM, last: 1'b0};
        expected_terms.push_back(t);
        n++;
      end
    end else if (op == OP_MUL) begin
      for (int e = 0; e < 63; e++) acc[e] = '0;
      for (int i = 0; i < 32; i++)
        for (int j = 0; j < 32; j++)
          if (poly_a_present[i] && poly_b_present[j])
            acc[i+j] = acc[i+j] +
                       ACC_W'(32'(poly_a_coef[i]) * 32'(poly_b_coef[j]));
      for (int e = 62; e >= 0; e--) begin
        if (acc[e] == '0) continue;
        t = '{exponent: EXP_OUT_W'(e), coefficient: acc[e], status: ST_TERM, last: 1'b0};
        expected_terms.push_back(t);
        n++;
      end
    end else begin
      expected_terms.push_back('{exponent: '0, coefficient: '0, status: ST_INVALID,
                                 last: 1'b0});
      n = 1;
    end
    if (n == 0)
      expected_terms.push_back('{exponent: '0, coefficient: '0, status: ST_EMPTY,
                                 last: 1'b0});
    expected_terms[$].last = 1'b1;
    poly_a_present = '0;
    poly_b_present = '0;
    computes_sent++;
  endfunction

  always @(posedge clk) begin
    term_t exp_t;
    if (rst_n && out_valid) begin
      terms_checked++;
      if (expected_terms.size() == 0) begin
        report($sformatf("unexpected beat exp=%0d coef=%0d", out_exponent, out_coefficient));
      end else begin
        exp_t = expected_terms.pop_front();
        if (out_exponent !== exp_t.exponent)
          report($sformatf("exponent %0d, want %0d", out_exponent, exp_t.exponent));
        if (out_coefficient !== exp_t.coefficient)
          report($sformatf("coefficient %0d, want %0d", out_coefficient,
                           $signed(exp_t.coefficient)));
        if (out_status !== exp_t.status)
          report($sformatf("status %0d, want %0d", out_status, exp_t.status));
        if (out_last_term !== exp_t.last)
          report($sformatf("last_term %0b, want %0b", out_last_term, exp_t.last));
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_item(logic [1:0] req, logic [4:0] ex, logic signed [15:0] coef,
                           logic [1:0] op);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      in_req_type <= 2'($urandom);
      in_term_exponent <= 5'($urandom);
      in_term_coefficient <= 16'($urandom);
      in_operation <= 2'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_term_exponent <= ex;
    in_term_coefficient <= coef;
    in_operation <= op;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_item(req, ex, coef, op);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(REQ_COMPUTE, 5'd0, 16'sd0, OP_ADD);
    send_item(REQ_COMPUTE, 5'd0, 16'sd0, OP_MUL);
    send_item(REQ_COMPUTE, 5'd0, 16'sd0, OP_BAD);
    send_item(REQ_LOAD_A, 5'd31, 16'sh7fff, OP_ADD);
    send_item(REQ_LOAD_A, 5'd0, 16'sh8000, OP_ADD);
    send_item(REQ_LOAD_B, 5'd31, 16'sh7fff, OP_ADD);
    send_item(REQ_LOAD_B, 5'd5, -16'sd3, OP_ADD);
    send_item(REQ_LOAD_B, 5'd5, 16'sd7, OP_ADD);
    send_item(REQ_UNUSED, 5'd5, 16'sd99, OP_ADD);
    send_item(REQ_COMPUTE, 5'd0, 16'sd0, OP_SUB);
    send_item(REQ_LOAD_A, 5'd31, 16'sh8000, OP_ADD);
    send_item(REQ_LOAD_A, 5'd30, 16'sh8000, OP_ADD);
    send_item(REQ_LOAD_B, 5'd31, 16'sh8000, OP_ADD);
    send_item(REQ_LOAD_B, 5'd30, 16'sh8000, OP_ADD);
    send_item(REQ_COMPUTE, 5'd0, 16'sd0, OP_MUL);
    send_item(REQ_LOAD_A, 5'd1, 16'sd4, OP_ADD);
    send_item(REQ_LOAD_B, 5'd1, -16'sd4, OP_ADD);
    send_item(REQ_COMPUTE, 5'd0, 16'sd0, OP_ADD);
    send_item(REQ_LOAD_A, 5'd2, 16'sd1, OP_ADD);
    send_item(REQ_LOAD_B, 5'd3, 16'sd1, OP_ADD);
    send_item(REQ_COMPUTE, 5'd0, 16'sd0, OP_BAD);
    send_item(REQ_COMPUTE, 5'd0, 16'sd0, OP_MUL);
  endtask

  task automatic test_random(int n_items);
    int n;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(2'($urandom_range(3)), 5'($urandom), 16'($urandom), 2'($urandom));
      end else begin
        int len;
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          logic signed [15:0] c;
          c = ($urandom_range(3) == 0) ? 16'($urandom) :
              16'($signed($urandom_range(0, 40)) - 20);
          send_item(2'($urandom_range(1)), 5'($urandom), c, 2'($urandom));
        end
        send_item(REQ_COMPUTE, 5'($urandom), 16'($urandom),
                  ($urandom_range(9) == 0) ? OP_BAD : 2'($urandom_range(2)));
        n += len;
      end
      n++;
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    items_sent = 0;
    terms_checked = 0;
    computes_sent = 0;
    send_gap_pct = 0;
    poly_a_present = '0;
    poly_b_present = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_LOAD_A;
    in_term_exponent = '0;
    in_term_coefficient = '0;
    in_operation = OP_ADD;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    send_gap_pct = 21;
    test_random(64);
    send_gap_pct = 72;
    test_random(64);
    send_gap_pct = 0;
    test_random(64);
    start <= 1'b0;
    while (expected_terms.size() != 0 && cycles < 390000) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("tb: %0d items sent, %0d computes, %0d result beats checked",
             items_sent, computes_sent, terms_checked);
    if (errors == 0 && expected_terms.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: %0d mismatches, %0d beats missing", errors, expected_terms.size());
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
